// ===== src/tbs_pkg.sv =====
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared constants and types for the text byte sanitiser: byte codes of the
// patterns, queue sizing and the bundle that travels from front to back.
// ----------------------------------------------------------------------------
package tbs_pkg;

   // Byte codes
   localparam logic [7:0] BYTE_NUL   = 8'h00;
   localparam logic [7:0] BYTE_TAB   = 8'h09;
   localparam logic [7:0] BYTE_LF    = 8'h0A;
   localparam logic [7:0] BYTE_CR    = 8'h0D;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_C2    = 8'hC2;
   localparam logic [7:0] BYTE_A0    = 8'hA0;
   localparam logic [7:0] BYTE_EF    = 8'hEF;
   localparam logic [7:0] BYTE_BB    = 8'hBB;
   localparam logic [7:0] BYTE_BF    = 8'hBF;
   localparam logic [7:0] BYTE_E2    = 8'hE2;
   localparam logic [7:0] BYTE_80    = 8'h80;
   localparam logic [7:0] BYTE_8B    = 8'h8B;
   localparam logic [7:0] BYTE_8C    = 8'h8C;
   localparam logic [7:0] BYTE_8D    = 8'h8D;

   // Results one input can cause, and bundle queue depth
   localparam int MAX_RESULTS = 4;
   localparam int QUEUE_DEPTH = 2;

   // All results of one input, as handed from front to back
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] bytes;    // result bytes, first in entry 0
      logic [1:0]                  last_idx; // index of the last result
      logic                        has_byte; // 0: single byte-less end result
      logic                        done;     // input ended the string
   } bundle_type;

   // Queue status seen by the front
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== src/tbs_front.sv =====
// ----------------------------------------------------------------------------
// tbs_front
// Accepts input beats, runs the pattern match and space collapsing for one
// byte per beat, and pushes the resulting bundle into the queue.
// ----------------------------------------------------------------------------
module tbs_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,   // [7:0] byte_value
   input  logic                    req_tuser,   // [0] byte_present
   input  logic                    req_tlast,   // end_of_string
   input  tbs_pkg::q_status_type   q_status,
   output logic                    push,
   output tbs_pkg::bundle_type     push_data
);

   // Running result list while cleaning one beat
   typedef struct packed {
      logic [tbs_pkg::MAX_RESULTS-1:0][7:0] bytes;
      logic [2:0]                           cnt;
      logic                                 sp;
      logic                                 ts;
   } clean_type;

   // Append one byte; excess beyond the result limit is dropped
   function automatic clean_type put_byte(clean_type s, logic [7:0] b);
      clean_type r;
      r = s;
      if (r.cnt < 3'(tbs_pkg::MAX_RESULTS)) begin
         r.bytes[r.cnt[1:0]] = b;
         r.cnt = r.cnt + 3'd1;
      end
      return r;
   endfunction

   // Collapse runs of spaces and trim the leading ones
   function automatic clean_type send_clean(clean_type s, logic [7:0] c);
      clean_type r;
      r = s;
      if (c == tbs_pkg::BYTE_SPACE) begin
         if (r.ts) begin
            r.sp = 1'b1;
         end
      end else begin
         if (r.sp) begin
            r = put_byte(r, tbs_pkg::BYTE_SPACE);
         end
         r = put_byte(r, c);
         r.sp = 1'b0;
         r.ts = 1'b1;
      end
      return r;
   endfunction

   // State
   logic [7:0] held0_ff, held1_ff, held0_in, held1_in;
   logic [1:0] held_cnt_ff, held_cnt_in;
   logic       space_pend_ff, space_pend_in;
   logic       started_ff, started_in;

   // Scan working signals
   logic [7:0] win [0:4];
   logic [1:0] win_n;
   logic [1:0] skip;
   logic [1:0] rem;
   logic       stop;
   logic [7:0] c;
   logic [7:0] second;
   logic       hit;
   logic [1:0] hold_cnt;
   logic [7:0] hold0, hold1;
   clean_type  cl;
   logic       accept;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;

   // Pattern scan over held bytes plus the new byte, then end-of-string flush
   always_comb begin
      win[0] = held0_ff;
      win[1] = held1_ff;
      win[2] = req_tdata;
      win[3] = tbs_pkg::BYTE_NUL;
      win[4] = tbs_pkg::BYTE_NUL;
      case (held_cnt_ff)
         2'd0: begin
            win[0] = req_tdata;
            win_n  = 2'd1;
         end
         2'd1: begin
            win[1] = req_tdata;
            win_n  = 2'd2;
         end
         default: begin
            win_n = 2'd3;
         end
      endcase

      cl.bytes = '0;
      cl.cnt   = 3'd0;
      cl.sp    = space_pend_ff;
      cl.ts    = started_ff;
      skip     = 2'd0;
      stop     = 1'b0;
      rem      = 2'd0;
      c        = tbs_pkg::BYTE_NUL;
      second   = tbs_pkg::BYTE_NUL;
      hit      = 1'b0;
      hold_cnt = held_cnt_ff;
      hold0    = held0_ff;
      hold1    = held1_ff;

      if (req_tuser) begin
         hold_cnt = 2'd0;
         for (int i = 0; i < 3; i++) begin
            if ((2'(i) < win_n) && !stop) begin
               if (skip != 2'd0) begin
                  skip = skip - 2'd1;
               end else begin
                  c      = win[i];
                  rem    = win_n - 2'(i);
                  second = (c == tbs_pkg::BYTE_EF) ? tbs_pkg::BYTE_BB : tbs_pkg::BYTE_80;
                  hit    = (c == tbs_pkg::BYTE_EF) ? (win[i+2] == tbs_pkg::BYTE_BF)
                                                   : (win[i+2] == tbs_pkg::BYTE_8B ||
                                                      win[i+2] == tbs_pkg::BYTE_8C ||
                                                      win[i+2] == tbs_pkg::BYTE_8D);
                  if (c == tbs_pkg::BYTE_NUL) begin
                     // dropped
                  end else if (c == tbs_pkg::BYTE_C2 && rem == 2'd1) begin
                     stop = 1'b1;
                  end else if (c == tbs_pkg::BYTE_C2 && win[i+1] == tbs_pkg::BYTE_A0) begin
                     cl   = send_clean(cl, tbs_pkg::BYTE_SPACE);
                     skip = 2'd1;
                  end else if ((c == tbs_pkg::BYTE_EF || c == tbs_pkg::BYTE_E2) &&
                               rem == 2'd1) begin
                     stop = 1'b1;
                  end else if ((c == tbs_pkg::BYTE_EF || c == tbs_pkg::BYTE_E2) &&
                               win[i+1] == second && rem == 2'd2) begin
                     stop = 1'b1;
                  end else if ((c == tbs_pkg::BYTE_EF || c == tbs_pkg::BYTE_E2) &&
                               win[i+1] == second && hit) begin
                     skip = 2'd2;
                  end else if (c == tbs_pkg::BYTE_TAB || c == tbs_pkg::BYTE_LF ||
                               c == tbs_pkg::BYTE_CR) begin
                     cl = send_clean(cl, tbs_pkg::BYTE_SPACE);
                  end else begin
                     cl = send_clean(cl, c);
                  end
                  // partial prefix: keep the rest of the window
                  if (stop) begin
                     hold_cnt = rem;
                     hold0    = win[i];
                     hold1    = win[i+1];
                  end
               end
            end
         end
      end

      // end of string: held bytes go out unchanged
      if (req_tlast) begin
         if (hold_cnt != 2'd0) begin
            cl = send_clean(cl, hold0);
         end
         if (hold_cnt == 2'd2) begin
            cl = send_clean(cl, hold1);
         end
      end
   end

   // Bundle and push
   always_comb begin
      push               = accept && (req_tlast || cl.cnt != 3'd0);
      push_data.bytes    = cl.bytes;
      push_data.has_byte = (cl.cnt != 3'd0);
      push_data.last_idx = (cl.cnt == 3'd0) ? 2'd0 : 2'(cl.cnt - 3'd1);
      push_data.done     = req_tlast;
   end

   // Next state
   always_comb begin
      held0_in      = held0_ff;
      held1_in      = held1_ff;
      held_cnt_in   = held_cnt_ff;
      space_pend_in = space_pend_ff;
      started_in    = started_ff;
      if (accept) begin
         if (req_tlast) begin
            held_cnt_in   = 2'd0;
            space_pend_in = 1'b0;
            started_in    = 1'b0;
         end else begin
            held0_in      = hold0;
            held1_in      = hold1;
            held_cnt_in   = hold_cnt;
            space_pend_in = cl.sp;
            started_in    = cl.ts;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_cnt_ff   <= 2'd0;
         space_pend_ff <= 1'b0;
         started_ff    <= 1'b0;
      end else begin
         held_cnt_ff   <= held_cnt_in;
         space_pend_ff <= space_pend_in;
         started_ff    <= started_in;
      end
   end

   // Held prefix bytes, read only below the held count
   always_ff @(posedge clock) begin
      held0_ff <= held0_in;
      held1_ff <= held1_in;
   end

endmodule

// ===== src/tbs_queue.sv =====
// ----------------------------------------------------------------------------
// tbs_queue
// Small register queue of result bundles between front and back.
// ----------------------------------------------------------------------------
module tbs_queue #(
   parameter int DEPTH = tbs_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tbs_pkg::bundle_type   push_data,
   input  logic                  pop,
   output tbs_pkg::bundle_type   head,
   output tbs_pkg::q_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   tbs_pkg::bundle_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/tbs_back.sv =====
// ----------------------------------------------------------------------------
// tbs_back
// Walks the head bundle one result per beat into the output register.
// ----------------------------------------------------------------------------
module tbs_back (
   input  logic                  clock,
   input  logic                  reset,
   input  tbs_pkg::bundle_type   head,
   input  tbs_pkg::q_status_type q_status,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,  // [7:0] out_byte
   output logic [1:0]            rsp_tuser,  // [0] byte_valid, [1] string_done
   output logic                  rsp_tlast   // last_of_run
);

   logic [1:0] pos_ff, pos_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic [1:0] user_ff, user_in;
   logic       last_ff, last_in;
   logic       load;
   logic       at_last;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

   // Output register loads when empty or being taken
   always_comb begin
      load    = !q_status.empty && (!valid_ff || rsp_tready);
      at_last = (pos_ff == head.last_idx);
      pop     = load && at_last;
      pos_in  = pos_ff;
      if (load) begin
         pos_in = at_last ? 2'd0 : pos_ff + 2'd1;
      end
      valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
      data_in  = head.bytes[pos_ff];
      user_in  = {head.done && at_last, head.has_byte};
      last_in  = at_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
         user_ff <= user_in;
         last_ff <= last_in;
      end
   end

endmodule

// ===== src/text_byte_sanitizer_unit.sv =====
// ----------------------------------------------------------------------------
// text_byte_sanitizer_unit
// Cleans a byte stream: drops NUL, BOM and zero-width marks, maps NBSP, tab,
// LF and CR to space, collapses space runs and trims both ends of a string.
//
//  channel | dir | tdata             | tuser                          | tlast
//  req_    | in  | [7:0] byte_value  | [0] byte_present               | end_of_string
//  rsp_    | out | [7:0] out_byte    | [0] byte_valid, [1] string_done| last_of_run
//
// A beat is taken every cycle while the bundle queue has room; the front
// classifies it combinationally as it is accepted. The back sends one result
// per cycle from the output register while rsp_tready is high, so a beat with
// k results (1..4) occupies it for k transfers; no-result beats are not queued.
// Synchronous reset clears the prefix count and space state; no clearing pass.
// The queue lets the input keep flowing while the output is stalled.
// ----------------------------------------------------------------------------
module text_byte_sanitizer_unit #(
   parameter int QUEUE_DEPTH = tbs_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] byte_value
   input  logic       req_tuser,   // [0] byte_present
   input  logic       req_tlast,   // end_of_string
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [0] byte_valid, [1] string_done
   output logic       rsp_tlast    // last_of_run
);

   tbs_pkg::q_status_type q_status;
   tbs_pkg::bundle_type   push_data;
   tbs_pkg::bundle_type   head;
   logic                  push;
   logic                  pop;

   // Front: accept and classify
   tbs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .push       (push),
      .push_data  (push_data)
   );

   // Bundle queue
   tbs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   // Back: serialise results
   tbs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // String end is flagged only on the final result of a beat
   a_done_is_last : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("string_done without last_of_run");

   // A byte-less result is only the empty end-of-string marker
   a_empty_result : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tuser[1] && rsp_tdata == 8'h00)
      else $error("byte-less result outside string end");

   // Queue cannot be full and empty at once
   a_queue_status : assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue full and empty together");

   // Nothing is presented straight after reset
   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

// ===== tb/text_byte_sanitizer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// text_byte_sanitizer_unit_tb
// Self-checking bench for the text byte sanitiser. Strings go in one beat at a
// time with random gaps, and results come out under random back-pressure. A
// scoreboard works out the cleaned bytes of every accepted beat and checks
// each result beat against the oldest one still owed.
// ----------------------------------------------------------------------------
module text_byte_sanitizer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 260;
   localparam int DRAIN_CYCLES = 40;

   // One input beat
   typedef struct packed {
      logic [7:0] value;
      logic       present;
      logic       eos;
   } req_item_type;

   // One result beat
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last_of_run;
      logic       string_done;
   } rsp_beat_type;

   // Kinds of text fragment for the random strings
   typedef enum {
      FRAG_PRINTABLE, FRAG_SPACE, FRAG_WHITESPACE, FRAG_NUL, FRAG_NBSP,
      FRAG_BOM, FRAG_ZERO_WIDTH, FRAG_BROKEN, FRAG_PREFIX_ONLY, FRAG_ANY_BYTE,
      FRAG_IDLE_STEP
   } frag_kind_type;

   // -------------------------------------------------------------------------
   // Scoreboard: cleans each accepted beat and holds the results still owed
   // -------------------------------------------------------------------------
   class sanitizer_scoreboard;
      logic [7:0]   held [2];
      int unsigned  held_count;
      bit           space_pending;
      bit           text_started;
      logic [7:0]   step_bytes [tbs_pkg::MAX_RESULTS];
      int unsigned  step_count;
      rsp_beat_type owed_beats [$];
      int unsigned  fail_count;

      function new();
         clear_string();
         fail_count = 0;
      endfunction

      function void clear_string();
         held_count    = 0;
         space_pending = 1'b0;
         text_started  = 1'b0;
      endfunction

      // Only as many bytes as one beat can carry out are kept
      function void push_byte(logic [7:0] b);
         if (step_count >= tbs_pkg::MAX_RESULTS) return;
         step_bytes[step_count] = b;
         step_count++;
      endfunction

      // Space collapsing and trimming
      function void emit_clean(logic [7:0] c);
         if (c == tbs_pkg::BYTE_SPACE) begin
            if (text_started) space_pending = 1'b1;
            return;
         end
         if (space_pending) push_byte(tbs_pkg::BYTE_SPACE);
         push_byte(c);
         space_pending = 1'b0;
         text_started  = 1'b1;
      endfunction

      // Pattern matching over the held prefix plus the new byte
      function void match_patterns(logic [7:0] nb);
         logic [7:0]  window [3];
         logic [7:0]  c;
         logic [7:0]  second;
         logic [7:0]  third;
         int unsigned n;
         int unsigned pos;
         int unsigned rem;
         int unsigned i;
         bit          hold;
         n = 0;
         pos = 0;
         for (i = 0; i < held_count && i < 2; i++) begin
            window[n] = held[i];
            n++;
         end
         window[n] = nb;
         n++;
         held_count = 0;

         while (pos < n) begin
            c = window[pos];
            rem = n - pos;
            hold = 1'b0;
            if (c == tbs_pkg::BYTE_NUL) begin
               pos++;
               continue;
            end
            if (c == tbs_pkg::BYTE_C2) begin
               if (rem == 1) begin
                  hold = 1'b1;
               end else if (window[pos+1] == tbs_pkg::BYTE_A0) begin
                  emit_clean(tbs_pkg::BYTE_SPACE);
                  pos += 2;
                  continue;
               end
            end else if (c == tbs_pkg::BYTE_EF || c == tbs_pkg::BYTE_E2) begin
               second = (c == tbs_pkg::BYTE_EF) ? tbs_pkg::BYTE_BB : tbs_pkg::BYTE_80;
               if (rem == 1) begin
                  hold = 1'b1;
               end else if (window[pos+1] == second) begin
                  if (rem == 2) begin
                     hold = 1'b1;
                  end else begin
                     third = window[pos+2];
                     if ((c == tbs_pkg::BYTE_EF && third == tbs_pkg::BYTE_BF) ||
                         (c == tbs_pkg::BYTE_E2 && (third == tbs_pkg::BYTE_8B ||
                                                    third == tbs_pkg::BYTE_8C ||
                                                    third == tbs_pkg::BYTE_8D))) begin
                        pos += 3;
                        continue;
                     end
                  end
               end
            end
            // possible prefix runs to the end of the window: keep it
            if (hold) begin
               for (i = 0; pos + i < n && i < 2; i++) held[i] = window[pos+i];
               held_count = i;
               return;
            end
            if (c == tbs_pkg::BYTE_TAB || c == tbs_pkg::BYTE_LF || c == tbs_pkg::BYTE_CR)
               emit_clean(tbs_pkg::BYTE_SPACE);
            else
               emit_clean(c);
            pos++;
         end
      endfunction

      // Accepted input beat: work out every result it causes
      function void note_input(logic [7:0] value, logic present, logic eos);
         rsp_beat_type beat;
         int unsigned  i;
         step_count = 0;
         if (present) match_patterns(value);
         if (eos) begin
            // held bytes leave unchanged; a trailing space is dropped
            for (i = 0; i < held_count && i < 2; i++) emit_clean(held[i]);
            if (step_count == 0) begin
               beat.out_byte    = 8'h00;
               beat.byte_valid  = 1'b0;
               beat.last_of_run = 1'b1;
               beat.string_done = 1'b1;
               owed_beats = {owed_beats, beat};
            end
            clear_string();
         end
         for (i = 0; i < step_count; i++) begin
            beat.out_byte    = step_bytes[i];
            beat.byte_valid  = 1'b1;
            beat.last_of_run = (i == step_count - 1);
            beat.string_done = eos && (i == step_count - 1);
            owed_beats = {owed_beats, beat};
         end
      endfunction

      // Accepted result beat: compare with the oldest owed result
      function void check_result(logic [7:0] data, logic [1:0] user, logic last);
         rsp_beat_type want;
         if (owed_beats.size() == 0) begin
            $display("%0t: unexpected result beat data=%h user=%b last=%b",
                     $time, data, user, last);
            fail_count++;
            return;
         end
         want = owed_beats.pop_front();
         if (data !== want.out_byte) begin
            $display("%0t: out_byte expected %h got %h", $time, want.out_byte, data);
            fail_count++;
         end
         if (user[0] !== want.byte_valid) begin
            $display("%0t: byte_valid expected %b got %b", $time, want.byte_valid, user[0]);
            fail_count++;
         end
         if (user[1] !== want.string_done) begin
            $display("%0t: string_done expected %b got %b", $time, want.string_done, user[1]);
            fail_count++;
         end
         if (last !== want.last_of_run) begin
            $display("%0t: last_of_run expected %b got %b", $time, want.last_of_run, last);
            fail_count++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and block
   // -------------------------------------------------------------------------
   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] byte_value
   logic       req_tuser  = 1'b0;    // [0] byte_present
   logic       req_tlast  = 1'b0;    // end_of_string
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] out_byte
   logic [1:0] rsp_tuser;            // [0] byte_valid, [1] string_done
   logic       rsp_tlast;            // last_of_run

   sanitizer_scoreboard sb = new();
   req_item_type        stim_q [$];
   int unsigned         stim_count = 0;
   int unsigned         cycles     = 0;
   bit                  calm       = 1'b0;   // no idling on either side while set

   text_byte_sanitizer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Clock
   initial begin
      forever #5 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Idle length: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   // Queue one stimulus beat; idle steps are not counted
   task automatic add_item(logic [7:0] value, logic present, logic eos);
      req_item_type it;
      it.value   = value;
      it.present = present;
      it.eos     = eos;
      stim_q = {stim_q, it};
      if (present || eos) stim_count++;
   endtask

   // Present one beat after a random gap and wait for it to be taken
   task automatic drive_item(req_item_type it);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= it.value;
      req_tuser  <= it.present;
      req_tlast  <= it.eos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_input(it.value, it.present, it.eos);
   endtask

   // Result side back-pressure
   initial begin
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // Stimulus
   initial begin
      int unsigned      random_start;
      int unsigned      frags;
      int unsigned      r;
      frag_kind_type    kind;
      logic [7:0]       lead;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty string closed by a bare end mark
      add_item(8'h5A, 1'b0, 1'b1);
      // leading blanks, NUL, NBSP, BOM, zero-width space, LF/CR run, trailing space
      add_item(tbs_pkg::BYTE_SPACE, 1'b1, 1'b0);
      add_item(tbs_pkg::BYTE_TAB,   1'b1, 1'b0);
      add_item(8'h41,               1'b1, 1'b0);
      add_item(tbs_pkg::BYTE_NUL,   1'b1, 1'b0);
      add_item(tbs_pkg::BYTE_C2,    1'b1, 1'b0);
      add_item(tbs_pkg::BYTE_A0,    1'b1, 1'b0);
      add_item(8'h42,               1'b1, 1'b0);
      add_item(tbs_pkg::BYTE_EF,    1'b1, 1'b0);
      add_item(tbs_pkg::BYTE_BB,    1'b1, 1'b0);
      add_item(tbs_pkg::BYTE_BF,    1'b1, 1'b0);
      add_item(tbs_pkg::BYTE_E2,    1'b1, 1'b0);
      add_item(tbs_pkg::BYTE_80,    1'b1, 1'b0);
      add_item(tbs_pkg::BYTE_8B,    1'b1, 1'b0);
      add_item(tbs_pkg::BYTE_LF,    1'b1, 1'b0);
      add_item(tbs_pkg::BYTE_CR,    1'b1, 1'b0);
      add_item(8'hFF,               1'b1, 1'b0);
      add_item(tbs_pkg::BYTE_SPACE, 1'b1, 1'b1);
      // prefix mismatches, idle step inside a held prefix, prefix held at end
      add_item(8'h7F,               1'b1, 1'b0);
      add_item(tbs_pkg::BYTE_E2,    1'b1, 1'b0);
      add_item(tbs_pkg::BYTE_80,    1'b1, 1'b0);
      add_item(8'h41,               1'b1, 1'b0);
      add_item(tbs_pkg::BYTE_E2,    1'b1, 1'b0);
      add_item(tbs_pkg::BYTE_80,    1'b1, 1'b0);
      add_item(8'hA5,               1'b0, 1'b0);
      add_item(tbs_pkg::BYTE_8D,    1'b1, 1'b0);
      add_item(tbs_pkg::BYTE_C2,    1'b1, 1'b0);
      add_item(8'h43,               1'b1, 1'b0);
      add_item(tbs_pkg::BYTE_E2,    1'b1, 1'b0);
      add_item(tbs_pkg::BYTE_80,    1'b1, 1'b1);

      // Random strings, mostly well-formed fragments
      random_start = stim_count;
      while (stim_count - random_start < RANDOM_ITEMS) begin
         frags = $urandom_range(1, 12);
         repeat (frags) begin
            r = $urandom_range(0, 99);
            if      (r < 28) kind = FRAG_PRINTABLE;
            else if (r < 40) kind = FRAG_SPACE;
            else if (r < 48) kind = FRAG_WHITESPACE;
            else if (r < 52) kind = FRAG_NUL;
            else if (r < 60) kind = FRAG_NBSP;
            else if (r < 66) kind = FRAG_BOM;
            else if (r < 74) kind = FRAG_ZERO_WIDTH;
            else if (r < 82) kind = FRAG_BROKEN;
            else if (r < 87) kind = FRAG_PREFIX_ONLY;
            else if (r < 96) kind = FRAG_ANY_BYTE;
            else             kind = FRAG_IDLE_STEP;
            lead = ($urandom_range(0, 1) != 0) ? tbs_pkg::BYTE_E2 : tbs_pkg::BYTE_EF;
            case (kind)
               FRAG_PRINTABLE:  add_item(8'($urandom_range(8'h21, 8'h7E)), 1'b1, 1'b0);
               FRAG_SPACE:      add_item(tbs_pkg::BYTE_SPACE, 1'b1, 1'b0);
               FRAG_WHITESPACE: begin
                  r = $urandom_range(0, 2);
                  add_item((r == 0) ? tbs_pkg::BYTE_TAB :
                           (r == 1) ? tbs_pkg::BYTE_LF : tbs_pkg::BYTE_CR, 1'b1, 1'b0);
               end
               FRAG_NUL:        add_item(tbs_pkg::BYTE_NUL, 1'b1, 1'b0);
               FRAG_NBSP: begin
                  add_item(tbs_pkg::BYTE_C2, 1'b1, 1'b0);
                  add_item(tbs_pkg::BYTE_A0, 1'b1, 1'b0);
               end
               FRAG_BOM: begin
                  add_item(tbs_pkg::BYTE_EF, 1'b1, 1'b0);
                  add_item(tbs_pkg::BYTE_BB, 1'b1, 1'b0);
                  add_item(tbs_pkg::BYTE_BF, 1'b1, 1'b0);
               end
               FRAG_ZERO_WIDTH: begin
                  r = $urandom_range(0, 2);
                  add_item(tbs_pkg::BYTE_E2, 1'b1, 1'b0);
                  add_item(tbs_pkg::BYTE_80, 1'b1, 1'b0);
                  add_item((r == 0) ? tbs_pkg::BYTE_8B :
                           (r == 1) ? tbs_pkg::BYTE_8C : tbs_pkg::BYTE_8D, 1'b1, 1'b0);
               end
               // a pattern start followed by a byte that may not fit
               FRAG_BROKEN: begin
                  r = $urandom_range(0, 2);
                  if (r == 0) begin
                     add_item(tbs_pkg::BYTE_C2, 1'b1, 1'b0);
                  end else begin
                     add_item(lead, 1'b1, 1'b0);
                     if (r == 2)
                        add_item((lead == tbs_pkg::BYTE_E2) ? tbs_pkg::BYTE_80 :
                                 tbs_pkg::BYTE_BB, 1'b1, 1'b0);
                  end
                  add_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
               end
               // a bare pattern start, left for the next fragment or the end
               FRAG_PREFIX_ONLY: begin
                  r = $urandom_range(0, 2);
                  if (r == 0) begin
                     add_item(tbs_pkg::BYTE_C2, 1'b1, 1'b0);
                  end else begin
                     add_item(lead, 1'b1, 1'b0);
                     if (r == 2)
                        add_item((lead == tbs_pkg::BYTE_E2) ? tbs_pkg::BYTE_80 :
                                 tbs_pkg::BYTE_BB, 1'b1, 1'b0);
                  end
               end
               FRAG_ANY_BYTE:   add_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
               default:         add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            endcase
         end
         // close the string on its last byte or with a bare end mark
         if (stim_q[stim_q.size()-1].present && !stim_q[stim_q.size()-1].eos &&
             $urandom_range(0, 9) < 7)
            stim_q[stim_q.size()-1].eos = 1'b1;
         else
            add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end

      // Drive everything, with calm stretches now and then
      while (stim_q.size() > 0) begin
         if ($urandom_range(0, 39) == 0) calm = !calm;
         drive_item(stim_q.pop_front());
      end
      req_tvalid <= 1'b0;
      calm = 1'b0;

      while (sb.owed_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/tbs_pkg.sv
src/tbs_front.sv
src/tbs_queue.sv
src/tbs_back.sv
src/text_byte_sanitizer_unit.sv
tb/text_byte_sanitizer_unit_tb.sv
